>>> hw/rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Timeslice task scheduler package
// Shared widths, defaults, item kinds and the command bundle sent to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

    localparam int NUM_TASKS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int PERIOD_W = 16;
    localparam int ID_W     = 3;

    localparam int SLOT_IDS    = 1 << SLOT_W;
    localparam int MAX_RESULTS = 8;
    localparam int HIT_CNT_W   = $clog2(MAX_RESULTS);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_EXEC = 2'd1,
        KIND_ADD  = 2'd2,
        KIND_DEL  = 2'd3
    } kind_t;

    typedef struct packed {
        logic                tick;
        logic                add;
        logic                del;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period;
        logic                start;
        logic                adv;
        logic                abort;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/tts_if.sv
// ----------------------------------------------------------------------------
// Timeslice task scheduler channels
// Request channel (tick, exec, add, delete) and response channel (due task ids).
// ----------------------------------------------------------------------------
`default_nettype none

interface tts_req_if;
    logic                          valid;
    logic                          ready;
    logic [tts_pkg::KIND_W-1:0]    kind;
    logic [tts_pkg::SLOT_W-1:0]    slot;
    logic [tts_pkg::PERIOD_W-1:0]  period;

    modport source (output valid, output kind, output slot, output period, input ready);
    modport sink   (input valid, input kind, input slot, input period, output ready);
endinterface

interface tts_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [tts_pkg::ID_W-1:0]  task_id;
    logic                      last;

    modport source (output valid, output task_id, output last, input ready);
    modport sink   (input valid, input task_id, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tts_cell.sv
// ----------------------------------------------------------------------------
// Timeslice task scheduler slot cell
// Holds one task slot and passes the exec scan token on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_cell #(
    parameter int COUNT_BITS = tts_pkg::COUNT_BITS_DEF,
    parameter int CELL_IDX   = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tts_pkg::cell_cmd_t cmd,
    input  wire logic               token_in,
    output logic                    token_out,
    output logic                    hit
);

    localparam int SLOT_W = tts_pkg::SLOT_W;

    logic                  active_reg;
    logic                  active_next;
    logic                  pending_reg;
    logic                  pending_next;
    logic                  token_reg;
    logic                  token_next;
    logic [COUNT_BITS-1:0] period_reg;
    logic [COUNT_BITS-1:0] period_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic                  mine;

    assign mine      = (CELL_IDX < tts_pkg::SLOT_IDS) && (cmd.slot == SLOT_W'(CELL_IDX));
    assign cnt_dec   = cnt_reg - 1'b1;
    assign hit       = token_reg && active_reg && pending_reg;
    assign token_out = token_reg;

    always_comb
    begin
        active_next  = active_reg;
        pending_next = pending_reg;
        period_next  = period_reg;
        cnt_next     = cnt_reg;
        token_next   = token_reg;

        if (cmd.abort)
        begin
            token_next = 1'b0;
        end
        else if (cmd.adv || cmd.start)
        begin
            token_next = token_in;
        end

        if (cmd.adv && hit)
        begin
            pending_next = 1'b0;
        end

        if (cmd.tick && active_reg && (cnt_reg != '0))
        begin
            if (cnt_dec == '0)
            begin
                pending_next = 1'b1;
                cnt_next     = period_reg;
            end
            else
            begin
                cnt_next = cnt_dec;
            end
        end

        if (cmd.add && mine)
        begin
            active_next  = 1'b1;
            pending_next = 1'b0;
            period_next  = COUNT_BITS'(cmd.period);
            cnt_next     = COUNT_BITS'(cmd.period);
        end

        if (cmd.del && mine && active_reg)
        begin
            active_next  = 1'b0;
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            pending_reg <= 1'b0;
            token_reg   <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            pending_reg <= pending_next;
            token_reg   <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= period_next;
        cnt_reg    <= cnt_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/timeslice_task_scheduler.sv
// ----------------------------------------------------------------------------
// Timeslice task scheduler
// A chain of slot cells with periodic down counters and an exec scan that
// reports due slots in ascending order.
// ----------------------------------------------------------------------------
// Tick, add and delete transfers leave the request channel ready. An exec
// transfer starts a scan token that walks the chain of slot cells one cell
// per cycle while the response side does not stall. The request channel
// stays not ready until the scan and the handover of the final due task are
// done. A scan stops early after eight due tasks; any further due slots stay
// pending for the next exec. Each response transfer carries one due slot id,
// and last marks the final one.
`default_nettype none

module timeslice_task_scheduler #(
    parameter int NUM_TASKS  = tts_pkg::NUM_TASKS_DEF,
    parameter int COUNT_BITS = tts_pkg::COUNT_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tts_req_if.sink   req,
    tts_rsp_if.source rsp
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int ID_W  = tts_pkg::ID_W;
    localparam int HCW   = tts_pkg::HIT_CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [HCW-1:0]     hit_cnt_reg;
    logic [HCW-1:0]     hit_cnt_next;
    logic [ID_W-1:0]    held_id_reg;
    logic [ID_W-1:0]    held_id_next;
    logic               held_valid_reg;
    logic               held_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [ID_W-1:0]    out_id_reg;
    logic [ID_W-1:0]    out_id_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic [NUM_TASKS-1:0] tok_vec;
    logic [NUM_TASKS-1:0] tok_in;
    logic [NUM_TASKS-1:0] hit_vec;
    tts_pkg::cell_cmd_t   cmd;

    logic accept;
    logic token_hit;
    logic out_free;
    logic stall;
    logic adv;
    logic at_end;
    logic cap;

    assign req.ready   = (state_reg == ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign token_hit   = |hit_vec;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign stall       = (state_reg == ST_SCAN) && token_hit && held_valid_reg && !out_free;
    assign adv         = (state_reg == ST_SCAN) && !stall;
    assign at_end      = (idx_reg == IDX_W'(NUM_TASKS - 1));
    assign cap         = token_hit && (hit_cnt_reg == HCW'(tts_pkg::MAX_RESULTS - 1));

    assign rsp.valid   = out_valid_reg;
    assign rsp.task_id = out_id_reg;
    assign rsp.last    = out_last_reg;

    always_comb
    begin
        cmd.tick   = accept && (req.kind == tts_pkg::KIND_TICK);
        cmd.add    = accept && (req.kind == tts_pkg::KIND_ADD);
        cmd.del    = accept && (req.kind == tts_pkg::KIND_DEL);
        cmd.start  = accept && (req.kind == tts_pkg::KIND_EXEC);
        cmd.slot   = req.slot;
        cmd.period = req.period;
        cmd.adv    = adv;
        cmd.abort  = adv && cap;
    end

    for (genvar i = 0; i < NUM_TASKS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign tok_in[i] = cmd.start;
        end
        else
        begin : g_link
            assign tok_in[i] = tok_vec[i-1];
        end

        tts_cell #(
            .COUNT_BITS (COUNT_BITS),
            .CELL_IDX   (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .token_in  (tok_in[i]),
            .token_out (tok_vec[i]),
            .hit       (hit_vec[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        held_id_next    = held_id_reg;
        held_valid_next = held_valid_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next      = ST_SCAN;
                    idx_next        = '0;
                    hit_cnt_next    = '0;
                    held_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (adv)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (token_hit)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_id_next    = held_id_reg;
                            out_last_next  = 1'b0;
                        end
                        hit_cnt_next    = hit_cnt_reg + 1'b1;
                        held_id_next    = ID_W'(idx_reg);
                        held_valid_next = 1'b1;
                    end
                    if (cap || at_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!held_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = held_id_reg;
                    out_last_next   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            hit_cnt_reg    <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            hit_cnt_reg    <= hit_cnt_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_id_reg  <= held_id_next;
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
    end

    // The scan token exists exactly while a scan is running.
    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> $onehot(tok_vec))
        else $error("scan token lost or duplicated");

    a_no_token_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> (tok_vec == '0))
        else $error("scan token present outside a scan");

    // The token position counter tracks the cell that holds the token.
    a_idx_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> tok_vec[idx_reg])
        else $error("scan index out of step with token");

    // A stalled scan leaves the token where it is.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> $stable(tok_vec))
        else $error("token moved during a stall");

    // A held task is handed over before the block takes a new request.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !held_valid_reg)
        else $error("held task left behind after exec");

endmodule

`default_nettype wire
